/* hw/rtl/redt_pkg.sv */
package redt_pkg;

    // Field widths of the request and result transactions, the table record and the window register
    localparam int SLOT_W   = 6;
    localparam int WINDOW_W = 40;
    localparam int HASH_W   = 64;
    localparam int TIME_W   = 64;

    // Window after reset: (86400 - 3600) s in microseconds
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(64'd82800000000);

    // Request kinds
    localparam logic ACT_QUERY = 1'b0;
    localparam logic ACT_KEEP  = 1'b1;

    // How a keep picked its slot
    localparam logic [1:0] CHOICE_NONE  = 2'd0;
    localparam logic [1:0] CHOICE_MATCH = 2'd1;
    localparam logic [1:0] CHOICE_EMPTY = 2'd2;
    localparam logic [1:0] CHOICE_EVICT = 2'd3;

    typedef struct packed {
        logic              action;
        logic [HASH_W-1:0] event_hash;
        logic              channel_flag;
        logic [TIME_W-1:0] now_usec;
    } req_t;

    typedef struct packed {
        logic              already_posted;
        logic [SLOT_W-1:0] slot_written;
        logic [1:0]        slot_choice;
    } rsp_t;

    // One table record as stored in the RAM
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic              channel;
        logic [TIME_W-1:0] stamp;
    } rec_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;    // capture the input transaction
        logic scan_start;  // rewind the slot address, clear the scan results
        logic rd_step;     // read the current slot and advance
        logic commit;      // write the picked slot, load the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;   // current slot address is the last slot
        logic out_busy;    // output register holds a result not yet taken
    } sts_t;

endpackage

/* hw/rtl/redt_ram.sv */
module redt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/redt_ctrl.sv */
module redt_ctrl import redt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FLUSH  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req   = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            // last slot's read data is folded in during this cycle
            ST_FLUSH: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/redt_datapath.sv */
module redt_datapath import redt_pkg::*; #(
    parameter int SLOT_COUNT = 50
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  req_t                s_data,
    input  logic                cfg_valid,
    input  logic [WINDOW_W-1:0] cfg_data,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic                m_valid,
    input  logic                m_ready,
    output rsp_t                m_data
);

    localparam int IDX_W = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
    localparam int REC_W = $bits(rec_t);

    // Request and configuration
    req_t                req_reg;
    logic [WINDOW_W-1:0] window_reg;

    // Scan address and the read pipeline stage
    logic [IDX_W-1:0] addr_reg;
    logic             eval_vld_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic             eval_slotv_reg;

    // Per-slot written flags: an unwritten slot reads as all zero
    logic [SLOT_COUNT-1:0] valid_reg;

    // Scan results
    logic              hit_reg;
    logic              have_match_reg;
    logic [IDX_W-1:0]  match_at_reg;
    logic              have_empty_reg;
    logic [IDX_W-1:0]  empty_at_reg;
    logic [IDX_W-1:0]  oldest_at_reg;
    logic [TIME_W-1:0] oldest_time_reg;

    // Output register
    logic m_valid_reg;
    rsp_t m_data_reg;

    logic [REC_W-1:0]  rd_raw;
    rec_t              rd_rec;
    rec_t              eff_rec;
    rec_t              wr_rec;
    logic              is_match;
    logic [TIME_W-1:0] age;
    logic              recent;
    logic [IDX_W-1:0]  pick;
    logic [1:0]        choice;
    logic [7:0]        pick_wide;
    logic              do_write;
    rsp_t              rsp;

    assign do_write = cmd.commit && (req_reg.action == ACT_KEEP);
    assign wr_rec   = '{hash: req_reg.event_hash, channel: req_reg.channel_flag,
                        stamp: req_reg.now_usec};

    redt_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (pick),
        .wdata (wr_rec),
        .re    (cmd.rd_step),
        .raddr (addr_reg),
        .rdata (rd_raw)
    );

    assign rd_rec  = rd_raw;
    assign eff_rec = eval_slotv_reg ? rd_rec : '0;

    // Compare the slot under evaluation against the request
    assign is_match = (eff_rec.hash == req_reg.event_hash)
                   && (eff_rec.channel == req_reg.channel_flag);
    assign age      = req_reg.now_usec - eff_rec.stamp;
    assign recent   = age < TIME_W'(window_reg);

    // Slot selection for a keep
    always_comb begin
        if (have_match_reg) begin
            pick   = match_at_reg;
            choice = CHOICE_MATCH;
        end else if (have_empty_reg) begin
            pick   = empty_at_reg;
            choice = CHOICE_EMPTY;
        end else begin
            pick   = oldest_at_reg;
            choice = CHOICE_EVICT;
        end
    end

    assign pick_wide = 8'(pick);

    // Result transaction
    always_comb begin
        rsp = '0;
        if (req_reg.action == ACT_KEEP) begin
            rsp.slot_written = pick_wide[SLOT_W-1:0];
            rsp.slot_choice  = choice;
        end else begin
            rsp.already_posted = hit_reg;
            rsp.slot_choice    = CHOICE_NONE;
        end
    end

    // Request capture and window register
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_valid) begin
            window_reg <= cfg_data;
        end
    end

    // Address sweep and read pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg     <= '0;
            eval_vld_reg <= 1'b0;
        end else begin
            eval_vld_reg <= cmd.rd_step;
            if (cmd.scan_start) begin
                addr_reg <= '0;
            end else if (cmd.rd_step) begin
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_step) begin
            eval_idx_reg   <= addr_reg;
            eval_slotv_reg <= valid_reg[addr_reg];
        end
    end

    // Written flags, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (do_write) begin
            valid_reg[pick] <= 1'b1;
        end
    end

    // Fold one slot per cycle into the scan results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg        <= 1'b0;
            have_match_reg <= 1'b0;
            have_empty_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            hit_reg        <= 1'b0;
            have_match_reg <= 1'b0;
            have_empty_reg <= 1'b0;
        end else if (eval_vld_reg) begin
            if ((eff_rec.stamp != '0) && is_match && recent) begin
                hit_reg <= 1'b1;
            end
            if (!have_match_reg && is_match) begin
                have_match_reg <= 1'b1;
            end
            if (!have_empty_reg && (eff_rec.hash == '0)) begin
                have_empty_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_vld_reg) begin
            if (!have_match_reg && is_match) begin
                match_at_reg <= eval_idx_reg;
            end
            if (!have_empty_reg && (eff_rec.hash == '0)) begin
                empty_at_reg <= eval_idx_reg;
            end
            // strict compare keeps the lowest index on a tie
            if ((eval_idx_reg == '0) || (eff_rec.stamp < oldest_time_reg)) begin
                oldest_at_reg   <= eval_idx_reg;
                oldest_time_reg <= eff_rec.stamp;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign sts.out_busy  = m_valid_reg && !m_ready;
    assign sts.scan_last = (addr_reg == IDX_W'(SLOT_COUNT - 1));

endmodule

/* hw/rtl/recent_event_dedup_table_unit.sv */
// Recent event dedup table.
// Input channel s_valid/s_ready/s_data carries one request transaction:
// a query asks whether the same hash and channel flag was stamped within
// the window; a keep stamps a slot with hash, flag and now_usec.
// Result channel m_valid/m_ready/m_data returns exactly one transaction per
// request (already_posted for a query, slot_written and slot_choice for a keep).
// cfg_valid/cfg_ready/cfg_data writes the 40-bit window in microseconds;
// cfg_ready is always high. Write it only while no request is in flight.
// Each request sweeps the table RAM, one slot per cycle through its single
// read port; a flush state then folds in the last slot, and a commit state
// writes the picked slot for a keep and loads the output register.
// s_ready is high only while the controller is idle, so one request is in work
// at a time; a new request is accepted while the previous result still waits.
// If the receiver stalls, the finished request holds in the controller until
// the output register frees, then the block returns to idle.
// Reset (aresetn low, synchronous) marks all slots unwritten, which reads as
// zero hash, flag and time, and restores the window to 82800000000.
module recent_event_dedup_table_unit import redt_pkg::*; #(
    parameter int SLOT_COUNT = 50
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  req_t                s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rsp_t                m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WINDOW_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    redt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    redt_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* test/recent_event_dedup_table_unit_test.sv */
module recent_event_dedup_table_unit_test;
    import redt_pkg::*;

    localparam int SLOTS    = 50;
    localparam int POOL_N   = 16;
    localparam int SEG_N    = 6;
    localparam int SEG_LEN  = 115;
    localparam int RECENT_N = 40;

    // Scoreboard: own copy of the table and window, predicts each answer
    class dedup_scoreboard;
        logic [HASH_W-1:0]   tab_hash[SLOTS];
        logic                tab_chan[SLOTS];
        logic [TIME_W-1:0]   tab_time[SLOTS];
        logic [WINDOW_W-1:0] window;
        rsp_t                answer_q[$];
        int                  errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                tab_hash[i] = '0;
                tab_chan[i] = 1'b0;
                tab_time[i] = '0;
            end
            window = WINDOW_RESET;
            errors = 0;
        endfunction

        function void set_window(logic [WINDOW_W-1:0] v);
            window = v;
        endfunction

        function int pending();
            return answer_q.size();
        endfunction

        // Accepted request transaction: work out the answer, update the table
        function void note_request(req_t r);
            rsp_t              e;
            logic [TIME_W-1:0] age;
            bit                have_match;
            bit                have_empty;
            int                match_at;
            int                empty_at;
            int                oldest_at;
            int                pick;
            e          = '0;
            have_match = 0;
            have_empty = 0;
            match_at   = 0;
            empty_at   = 0;
            oldest_at  = 0;
            if (r.action == ACT_QUERY) begin
                for (int i = 0; i < SLOTS; i++) begin
                    age = r.now_usec - tab_time[i];
                    if (tab_time[i] != '0 && tab_hash[i] == r.event_hash &&
                        tab_chan[i] == r.channel_flag && age < TIME_W'(window)) begin
                        e.already_posted = 1'b1;
                        break;
                    end
                end
                e.slot_choice = CHOICE_NONE;
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!have_match && tab_hash[i] == r.event_hash &&
                        tab_chan[i] == r.channel_flag) begin
                        have_match = 1;
                        match_at   = i;
                    end
                    if (!have_empty && tab_hash[i] == '0) begin
                        have_empty = 1;
                        empty_at   = i;
                    end
                    if (tab_time[i] < tab_time[oldest_at])
                        oldest_at = i;
                end
                if (have_match) begin
                    pick          = match_at;
                    e.slot_choice = CHOICE_MATCH;
                end else if (have_empty) begin
                    pick          = empty_at;
                    e.slot_choice = CHOICE_EMPTY;
                end else begin
                    pick          = oldest_at;
                    e.slot_choice = CHOICE_EVICT;
                end
                tab_hash[pick]  = r.event_hash;
                tab_chan[pick]  = r.channel_flag;
                tab_time[pick]  = r.now_usec;
                e.slot_written  = SLOT_W'(pick);
            end
            answer_q.push_back(e);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Accepted result transaction: compare against the oldest answer
        task check_result(rsp_t got);
            rsp_t e;
            if (answer_q.size() == 0) begin
                report_mismatch($sformatf("result with none pending: %p", got));
            end else begin
                e = answer_q.pop_front();
                if (got.already_posted !== e.already_posted)
                    report_mismatch($sformatf("already_posted got %b exp %b",
                                              got.already_posted, e.already_posted));
                if (got.slot_written !== e.slot_written)
                    report_mismatch($sformatf("slot_written got %0d exp %0d",
                                              got.slot_written, e.slot_written));
                if (got.slot_choice !== e.slot_choice)
                    report_mismatch($sformatf("slot_choice got %0d exp %0d",
                                              got.slot_choice, e.slot_choice));
            end
        endtask
    endclass

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    req_t                s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    rsp_t                m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WINDOW_W-1:0] cfg_data  = '0;

    dedup_scoreboard     sb;
    int                  s_idle_pct = 13;
    int                  m_idle_pct = 45;

    logic [TIME_W-1:0]   cur_time;
    logic [31:0]         step_max;
    logic [HASH_W-1:0]   hash_pool[POOL_N];
    logic [HASH_W-1:0]   recent_hash[$];
    logic                recent_chan[$];

    recent_event_dedup_table_unit #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, check every accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result(m_data);
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    function automatic req_t mk_req(logic act, logic [HASH_W-1:0] h, logic ch,
                                    logic [TIME_W-1:0] now);
        req_t r;
        r.action       = act;
        r.event_hash   = h;
        r.channel_flag = ch;
        r.now_usec     = now;
        return r;
    endfunction

    // Offer one request transaction, optionally after an idle gap
    task send_req(req_t r);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    // Hold the sender off until every answer has come back
    task drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task write_window(logic [WINDOW_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_window(v);
    endtask

    // Random request: often recently kept keys (mostly for queries) so queries hit and keeps match
    task build_random(output req_t r);
        int p;
        int k;
        int t;
        r.action = ($urandom_range(99) < 50) ? ACT_KEEP : ACT_QUERY;
        p = $urandom_range(99);
        if (recent_hash.size() != 0 && p < ((r.action == ACT_QUERY) ? 60 : 35)) begin
            k              = $urandom_range(recent_hash.size() - 1);
            r.event_hash   = recent_hash[k];
            r.channel_flag = recent_chan[k] ^ ($urandom_range(99) < 20);
        end else if (p < 70) begin
            r.event_hash   = hash_pool[$urandom_range(POOL_N - 1)];
            r.channel_flag = 1'($urandom_range(1));
        end else begin
            r.event_hash   = {$urandom, $urandom};
            r.channel_flag = 1'($urandom_range(1));
        end
        t = $urandom_range(99);
        if (t < 70) begin
            cur_time   = cur_time + $urandom_range(step_max);
            r.now_usec = cur_time;
        end else if (t < 80) begin
            r.now_usec = cur_time;
        end else if (t < 88) begin
            // behind the stored times: the age wraps
            r.now_usec = cur_time - $urandom_range(step_max, 1);
        end else if (t < 96) begin
            cur_time   = {$urandom, $urandom};
            r.now_usec = cur_time;
        end else begin
            r.now_usec = '0;
        end
        if (r.action == ACT_KEEP) begin
            recent_hash.push_back(r.event_hash);
            recent_chan.push_back(r.channel_flag);
            if (recent_hash.size() > RECENT_N) begin
                void'(recent_hash.pop_front());
                void'(recent_chan.pop_front());
            end
        end
    endtask

    initial begin
        logic [WINDOW_W-1:0] seg_window[SEG_N];
        logic [31:0]         seg_step[SEG_N];
        req_t                r;
        sb = new();
        cur_time = 64'd5000;
        hash_pool[0] = '0;
        hash_pool[1] = '1;
        hash_pool[2] = 64'd1;
        hash_pool[3] = 64'h8000_0000_0000_0000;
        for (int i = 4; i < POOL_N; i++)
            hash_pool[i] = {$urandom, $urandom};

        seg_window[0] = WINDOW_RESET;         seg_step[0] = 32'hFFFF_FFFF;
        seg_window[1] = '0;                   seg_step[1] = 32'd1000;
        seg_window[2] = '1;                   seg_step[2] = 32'hFFFF_FFFF;
        seg_window[3] = 40'd1000;             seg_step[3] = 32'd600;
        seg_window[4] = WINDOW_W'({$urandom, $urandom});
        seg_step[4]   = 32'hFFFF_FFFF;
        seg_window[5] = 40'd1;                seg_step[5] = 32'd3;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset table, zero hash, zero time, extremes, wrap, window edge
        send_req(mk_req(ACT_QUERY, '0, 1'b0, 64'd5));
        send_req(mk_req(ACT_KEEP,  '0, 1'b0, 64'd0));
        send_req(mk_req(ACT_QUERY, '0, 1'b0, 64'd10));
        send_req(mk_req(ACT_KEEP,  '0, 1'b1, 64'd100));
        send_req(mk_req(ACT_QUERY, '0, 1'b1, 64'd200));
        send_req(mk_req(ACT_KEEP,  '1, 1'b1, '1));
        send_req(mk_req(ACT_QUERY, '1, 1'b1, '1));
        send_req(mk_req(ACT_QUERY, '1, 1'b0, '1));
        send_req(mk_req(ACT_QUERY, '1, 1'b1, 64'd5));
        send_req(mk_req(ACT_KEEP,  '1, 1'b1, 64'd1000));
        send_req(mk_req(ACT_QUERY, '1, 1'b1, 64'd1000 + TIME_W'(WINDOW_RESET) - 64'd1));
        send_req(mk_req(ACT_QUERY, '1, 1'b1, 64'd1000 + TIME_W'(WINDOW_RESET)));
        send_req(mk_req(ACT_KEEP,  '0, 1'b0, 64'd300));
        send_req(mk_req(ACT_KEEP,  64'h8000_0000_0000_0000, 1'b0, 64'd300));
        send_req(mk_req(ACT_QUERY, 64'h8000_0000_0000_0000, 1'b0, 64'd301));

        // Random segments, one window setting each
        for (int seg = 0; seg < SEG_N; seg++) begin
            if (seg < 2) begin
                s_idle_pct = 13;
                m_idle_pct = 45;
            end else if (seg < 4) begin
                s_idle_pct = 45;
                m_idle_pct = 13;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            drain();
            write_window(seg_window[seg]);
            step_max = seg_step[seg];
            for (int n = 0; n < SEG_LEN; n++) begin
                if (seg == 0 && n == 60)
                    drain();
                build_random(r);
                send_req(r);
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SLOTS + 10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/redt_pkg.sv
hw/rtl/redt_ram.sv
hw/rtl/redt_ctrl.sv
hw/rtl/redt_datapath.sv
hw/rtl/recent_event_dedup_table_unit.sv
test/recent_event_dedup_table_unit_test.sv
